@@ hw/rtl/blpi_pkg.sv @@
// Shared constants, codes and types of the bounded list block.
package blpi_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMD_W      = 3;
   localparam int POS_W      = 5;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 2;
   localparam int LEN_W      = 5;
   localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ_ALL = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   // What the back end has to do with one classified command.
   typedef enum logic [2:0] {
      OP_REPLY,
      OP_INSERT,
      OP_DEL_TAIL,
      OP_DEL_HEAD,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type         kind;
      logic [STAT_W-1:0]   status;
      logic [IDX_W-1:0]    idx;
      logic [VAL_W-1:0]    value;
   } op_type;

endpackage

@@ hw/rtl/bounded_list_positional_insert_top.sv @@
// Top level of the bounded ordered list with positional insert.
//
// This block keeps an ordered list of up to sixteen signed 32-bit values and
// takes one command word at a time: insert at the tail, at the head or at a
// 1-based position, delete at the tail or the head, or read out the whole
// list. Each command gives one result word, except a read-out of a non-empty
// list, which gives one word per element from head to tail with tlast on the
// final one. Errors (empty list, position out of range, full list) give a
// status code and leave the list untouched; unused command codes return
// status OK with the current length. A front end accepts and classifies each
// command against a length count that runs ahead of the list, a two-entry
// queue decouples it from the back end, and the back end computes the shifted
// register list combinationally and stores it whole. Inserts, deletes and
// error replies flow at one command per cycle while the result words are
// taken; a read-out holds the back end until its last element is issued,
// one element per cycle on the same terms. The read-out keeps its queue entry
// until its final word is issued, so meanwhile the front end accepts only one
// more command. An output register holds each result word until it is taken,
// and the back end keeps working into it whenever the word is being taken
// in the same cycle. The list contents need no clearing after reset: only
// entries below the length count are ever returned.
module bounded_list_positional_insert_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [blpi_pkg::CMD_W-1:0]        req_tuser,  // cmd
   input  logic [blpi_pkg::REQ_DATA_W-1:0]   req_tdata,  // position [4:0], item_value [36:5], pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [blpi_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // status [1:0], out_value [33:2],
                                                         // length_now [38:34], pad
   output logic                              rsp_tlast
);
   import blpi_pkg::*;

   logic   front_valid, front_ready;
   op_type front_op;
   logic   back_valid, back_ready;
   op_type back_op;

   blpi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .op_valid   (front_valid),
      .op_data    (front_op),
      .op_ready   (front_ready)
   );

   blpi_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_op),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_op)
   );

   blpi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (back_valid),
      .op_ready   (back_ready),
      .op_data    (back_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ hw/rtl/blpi_front.sv @@
// Front end: accepts command words and classifies them against a tracked length.
module blpi_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [blpi_pkg::CMD_W-1:0]        req_tuser,  // cmd
   input  logic [blpi_pkg::REQ_DATA_W-1:0]   req_tdata,  // position, item_value, zero pad
   output logic                              op_valid,
   output blpi_pkg::op_type                  op_data,
   input  logic                              op_ready
);
   import blpi_pkg::*;

   logic [CNT_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] item_value;
   logic [CMP_W-1:0] pos_ext, len_ext;
   logic             accept;

   assign position   = req_tdata[POS_W-1:0];
   assign item_value = req_tdata[POS_W+VAL_W-1:POS_W];
   assign pos_ext    = CMP_W'(position);
   assign len_ext    = CMP_W'(len_ff);
   assign req_tready = op_ready;
   assign op_valid   = req_tvalid;
   assign accept     = req_tvalid && op_ready;

   // The length seen here runs ahead of the back end by the queued commands,
   // which is what each new command will meet when it is carried out.
   always_comb begin
      op_data.kind   = OP_REPLY;
      op_data.status = ST_OK;
      op_data.idx    = '0;
      op_data.value  = item_value;
      len_in         = len_ff;
      case (req_tuser)
         CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_POS: begin
            if (req_tuser == CMD_INS_POS &&
                (position == '0 || pos_ext > len_ext + CMP_W'(1))) begin
               op_data.status = ST_RANGE;
            end else if (len_ff >= CNT_W'(DEPTH)) begin
               op_data.status = ST_FULL;
            end else begin
               op_data.kind = OP_INSERT;
               len_in       = len_ff + CNT_W'(1);
               if (req_tuser == CMD_INS_TAIL) begin
                  op_data.idx = IDX_W'(len_ff);
               end else if (req_tuser == CMD_INS_HEAD) begin
                  op_data.idx = '0;
               end else begin
                  op_data.idx = IDX_W'(pos_ext - CMP_W'(1));
               end
            end
         end
         CMD_DEL_TAIL, CMD_DEL_HEAD: begin
            if (len_ff == '0) begin
               op_data.status = ST_EMPTY;
            end else begin
               op_data.kind = (req_tuser == CMD_DEL_TAIL) ? OP_DEL_TAIL : OP_DEL_HEAD;
               len_in       = len_ff - CNT_W'(1);
            end
         end
         CMD_READ_ALL: begin
            if (len_ff == '0) begin
               op_data.status = ST_EMPTY;
            end else begin
               op_data.kind = OP_READ;
            end
         end
         default: begin
            op_data.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (accept) begin
         len_ff <= len_in;
      end
   end

endmodule

@@ hw/rtl/blpi_fifo.sv @@
// Short queue of classified commands between the front and back ends.
module blpi_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  blpi_pkg::op_type  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output blpi_pkg::op_type  pop_data
);
   import blpi_pkg::*;

   op_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   push, pop;

   assign push_ready = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

endmodule

@@ hw/rtl/blpi_back.sv @@
// Back end: holds the register list, carries out commands and drives result words.
module blpi_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              op_valid,
   output logic                              op_ready,
   input  blpi_pkg::op_type                  op_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [blpi_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // status, out_value, length_now, pad
   output logic                              rsp_tlast
);
   import blpi_pkg::*;

   logic [VAL_W-1:0]   list_ff [DEPTH];
   logic [VAL_W-1:0]   list_in [DEPTH];
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [IDX_W-1:0]   rd_idx;
   logic [VAL_W-1:0]   rd_val;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic [LEN_W-1:0]   length_ff;
   logic               last_ff, last_in;
   logic               issue, done;

   assign issue    = op_valid && (!rsp_valid_ff || rsp_tready);
   assign op_ready = issue && done;
   assign rd_idx   = (op_data.kind == OP_READ) ? rd_cnt_ff : IDX_W'(len_ff - CNT_W'(1));
   assign rd_val   = list_ff[rd_idx];

   always_comb begin
      list_in   = list_ff;
      len_in    = len_ff;
      rd_cnt_in = rd_cnt_ff;
      status_in = op_data.status;
      value_in  = '0;
      last_in   = 1'b1;
      done      = 1'b1;
      case (op_data.kind)
         OP_INSERT: begin
            // Every entry from the insert point up moves one place toward the tail.
            for (int i = 1; i < DEPTH; i++) begin
               if (IDX_W'(i) > op_data.idx) begin
                  list_in[i] = list_ff[i-1];
               end
            end
            list_in[op_data.idx] = op_data.value;
            len_in = len_ff + CNT_W'(1);
         end
         OP_DEL_TAIL: begin
            value_in = rd_val;
            len_in   = len_ff - CNT_W'(1);
         end
         OP_DEL_HEAD: begin
            value_in = list_ff[0];
            for (int i = 0; i < DEPTH - 1; i++) begin
               list_in[i] = list_ff[i+1];
            end
            len_in = len_ff - CNT_W'(1);
         end
         OP_READ: begin
            value_in  = rd_val;
            last_in   = (CNT_W'(rd_cnt_ff) + CNT_W'(1)) == len_ff;
            done      = last_in;
            rd_cnt_in = last_in ? '0 : rd_cnt_ff + IDX_W'(1);
         end
         default: begin
            value_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         list_ff   <= list_in;
         status_ff <= status_in;
         value_ff  <= value_in;
         length_ff <= LEN_W'(len_in);
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (issue) begin
            len_ff    <= len_in;
            rd_cnt_ff <= rd_cnt_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - STAT_W - VAL_W - LEN_W)'(0), length_ff, value_ff,
                        status_ff};

endmodule
